@@ hdl/calendar_date_day_stepper_unit_defines.svh @@
// assertion helpers for the date stepper, clocked on clk, quiet in reset
`ifndef CALENDAR_DATE_DAY_STEPPER_UNIT_DEFINES_SVH
`define CALENDAR_DATE_DAY_STEPPER_UNIT_DEFINES_SVH

// condition holds at every edge
`define CDDS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("date stepper invariant violated");

// antecedent at one edge implies consequent at the next
`define CDDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date stepper sequence violated");

`endif

@@ hdl/cdds_pkg.sv @@
`timescale 1ns / 1ps
package cdds_pkg;

    localparam logic [11:0] YEAR_FLOOR  = 12'd1752;
    localparam logic [11:0] YEAR_TOP    = 12'd2080;
    localparam logic [9:0]  DELTA_LIMIT = 10'd500;
    localparam logic [3:0]  RST_MONTH   = 4'd9;
    localparam logic [4:0]  RST_DAY     = 5'd8;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_YEAR  = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_BAD_DAY   = 3'd3,
        ST_EXCESS    = 3'd4,
        ST_BELOW     = 3'd5,
        ST_ABOVE     = 3'd6
    } status_t;

    // datapath operation per microstep
    typedef enum logic [2:0] {
        DP_ACCEPT,
        DP_NONE,
        DP_LOAD_CHECK,
        DP_DELTA_SETUP,
        DP_DAY_STEP,
        DP_COMMIT,
        DP_EMIT
    } dp_op_t;

    // branch condition per microstep
    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_IN_VALID,
        CND_IS_ADD,
        CND_DELTA_BAD,
        CND_LOOP_DONE,
        CND_OUT_FREE
    } cond_t;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_FETCH     = 3'd0;
    localparam upc_t UPC_DISPATCH  = 3'd1;
    localparam upc_t UPC_LOAD_CHK  = 3'd2;
    localparam upc_t UPC_DELTA_CHK = 3'd3;
    localparam upc_t UPC_DAY_LOOP  = 3'd4;
    localparam upc_t UPC_COMMIT    = 3'd5;
    localparam upc_t UPC_EMIT      = 3'd6;

    typedef struct packed {
        dp_op_t dp_op;
        cond_t  cond;
        upc_t   jump;   // taken when cond holds
        upc_t   seq;    // taken otherwise
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic is_add;
        logic delta_bad;
        logic loop_done;
    } cond_in_t;

    // microprogram
    function automatic ctrl_t cdds_ucode(input upc_t pc);
        ctrl_t w;
        unique case (pc)
            UPC_FETCH:     w = '{DP_ACCEPT,      CND_IN_VALID,  UPC_DISPATCH,  UPC_FETCH};
            UPC_DISPATCH:  w = '{DP_NONE,        CND_IS_ADD,    UPC_DELTA_CHK, UPC_LOAD_CHK};
            UPC_LOAD_CHK:  w = '{DP_LOAD_CHECK,  CND_ALWAYS,    UPC_COMMIT,    UPC_COMMIT};
            UPC_DELTA_CHK: w = '{DP_DELTA_SETUP, CND_DELTA_BAD, UPC_COMMIT,    UPC_DAY_LOOP};
            UPC_DAY_LOOP:  w = '{DP_DAY_STEP,    CND_LOOP_DONE, UPC_COMMIT,    UPC_DAY_LOOP};
            UPC_COMMIT:    w = '{DP_COMMIT,      CND_ALWAYS,    UPC_EMIT,      UPC_EMIT};
            UPC_EMIT:      w = '{DP_EMIT,        CND_OUT_FREE,  UPC_FETCH,     UPC_EMIT};
            default:       w = '{DP_NONE,        CND_ALWAYS,    UPC_FETCH,     UPC_FETCH};
        endcase
        return w;
    endfunction

    // leap rule for the span the block can hold; the non-leap century years are named
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != 12'd1700) && (y != 12'd1800)
            && (y != 12'd1900) && (y != 12'd2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] len;
        case (m) inside
            4'd2:                      len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/cdds_seq.sv @@
`timescale 1ns / 1ps
module cdds_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  cdds_pkg::cond_in_t cnd,
    output cdds_pkg::ctrl_t   ctrl
);
    import cdds_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic taken;

    assign ctrl = cdds_ucode(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            CND_ALWAYS:    taken = 1'b1;
            CND_IN_VALID:  taken = cnd.in_valid;
            CND_IS_ADD:    taken = cnd.is_add;
            CND_DELTA_BAD: taken = cnd.delta_bad;
            CND_LOOP_DONE: taken = cnd.loop_done;
            CND_OUT_FREE:  taken = cnd.out_free;
            default:       taken = 1'b1;
        endcase
        upc_next = taken ? ctrl.jump : ctrl.seq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ hdl/cdds_dp.sv @@
`timescale 1ns / 1ps
module cdds_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cdds_pkg::ctrl_t        ctrl,
    input  logic                   in_accept,
    input  logic                   opcode,
    input  logic [11:0]            load_year,
    input  logic [3:0]             load_month,
    input  logic [4:0]             load_day,
    input  logic signed [9:0]      day_delta,
    output logic                   is_add,
    output logic                   delta_bad,
    output logic                   loop_done,
    output cdds_pkg::date_t        cur_date,
    output cdds_pkg::status_t      status
);
    import cdds_pkg::*;

    logic        op_reg,    op_next;
    date_t       ld_reg,    ld_next;
    logic [9:0]  delta_reg, delta_next;
    date_t       wk_reg,    wk_next;
    logic [8:0]  cnt_reg,   cnt_next;
    logic        back_reg,  back_next;
    status_t     stat_reg,  stat_next;
    date_t       date_reg,  date_next;

    logic [9:0]  mag;
    status_t     load_stat;
    logic [4:0]  len_cur;
    logic [4:0]  len_prev;
    logic        roll_day;
    logic        step_err;
    logic        cnt_zero;

    assign mag       = delta_reg[9] ? (~delta_reg + 10'd1) : delta_reg;
    assign delta_bad = mag > DELTA_LIMIT;
    assign is_add    = op_reg;
    assign len_cur   = month_len(wk_reg.month, wk_reg.year);
    assign len_prev  = month_len(wk_reg.month - 4'd1, wk_reg.year);
    assign roll_day  = wk_reg.day >= len_cur;
    assign cnt_zero  = cnt_reg == 9'd0;
    // the move would leave the supported years
    assign step_err  = back_reg
        ? ((wk_reg.day <= 5'd1) && (wk_reg.month <= 4'd1) && (wk_reg.year <= YEAR_FLOOR + 12'd1))
        : (roll_day && (wk_reg.month >= 4'd12) && (wk_reg.year >= YEAR_TOP - 12'd1));
    assign loop_done = cnt_zero || step_err;
    assign cur_date  = date_reg;
    assign status    = stat_reg;

    always_comb
    begin
        if (ld_reg.year <= YEAR_FLOOR || ld_reg.year > YEAR_TOP)
            load_stat = ST_BAD_YEAR;
        else if (ld_reg.month < 4'd1 || ld_reg.month > 4'd12)
            load_stat = ST_BAD_MONTH;
        else if (ld_reg.day < 5'd1 || ld_reg.day > month_len(ld_reg.month, ld_reg.year))
            load_stat = ST_BAD_DAY;
        else
            load_stat = ST_OK;
    end

    always_comb
    begin
        op_next    = op_reg;
        ld_next    = ld_reg;
        delta_next = delta_reg;
        wk_next    = wk_reg;
        cnt_next   = cnt_reg;
        back_next  = back_reg;
        stat_next  = stat_reg;
        date_next  = date_reg;
        unique case (ctrl.dp_op)
            DP_ACCEPT:
            begin
                if (in_accept)
                begin
                    op_next    = opcode;
                    ld_next    = '{load_year, load_month, load_day};
                    delta_next = day_delta;
                end
            end
            DP_LOAD_CHECK:
            begin
                stat_next = load_stat;
                wk_next   = ld_reg;
            end
            DP_DELTA_SETUP:
            begin
                wk_next   = date_reg;
                cnt_next  = mag[8:0];
                back_next = delta_reg[9];
                stat_next = delta_bad ? ST_EXCESS : ST_OK;
            end
            DP_DAY_STEP:
            begin
                if (!cnt_zero)
                begin
                    cnt_next = cnt_reg - 9'd1;
                    if (step_err)
                        stat_next = back_reg ? ST_BELOW : ST_ABOVE;
                    if (back_reg)
                    begin
                        if (wk_reg.day <= 5'd1)
                        begin
                            if (wk_reg.month <= 4'd1)
                            begin
                                wk_next.year  = wk_reg.year - 12'd1;
                                wk_next.month = 4'd12;
                                wk_next.day   = 5'd31;
                            end
                            else
                            begin
                                wk_next.month = wk_reg.month - 4'd1;
                                wk_next.day   = len_prev;
                            end
                        end
                        else
                        begin
                            wk_next.day = wk_reg.day - 5'd1;
                        end
                    end
                    else
                    begin
                        if (roll_day)
                        begin
                            wk_next.day = 5'd1;
                            if (wk_reg.month >= 4'd12)
                            begin
                                wk_next.year  = wk_reg.year + 12'd1;
                                wk_next.month = 4'd1;
                            end
                            else
                            begin
                                wk_next.month = wk_reg.month + 4'd1;
                            end
                        end
                        else
                        begin
                            wk_next.day = wk_reg.day + 5'd1;
                        end
                    end
                end
            end
            DP_COMMIT:
            begin
                if (stat_reg == ST_OK)
                    date_next = wk_reg;
            end
            DP_NONE, DP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        ld_reg    <= ld_next;
        delta_reg <= delta_next;
        wk_reg    <= wk_next;
        cnt_reg   <= cnt_next;
        back_reg  <= back_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= ST_OK;
            date_reg <= '{YEAR_FLOOR, RST_MONTH, RST_DAY};
        end
        else
        begin
            stat_reg <= stat_next;
            date_reg <= date_next;
        end
    end

endmodule

@@ hdl/calendar_date_day_stepper_unit.sv @@
`timescale 1ns / 1ps
// gregorian date counter driven by a small microprogram
// input stream: one word per command; tuser carries the opcode (0 load, 1 add),
//   tdata carries the date to load and the signed day count
// output stream: one word per command with the stored date after the command and
//   a status code (ok, bad year/month/day, excessive delta, below or above range)
// a load passes from the accepting edge through the dispatch, load check, commit and
//   emit steps to the result register; an add runs the delta check, then the day loop,
//   which moves one day per cycle through a single calendar stepper, then commit and emit;
//   a range error leaves the loop at the day it occurs
// one command is in work at a time: tready is high only in the fetch step, so the
//   next word is taken once the previous result is in the output register
// the output register lets a new word be accepted while the last result waits
// if the receiver stalls, the sequencer holds in the emit step until the
//   output register frees up, and no input is taken meanwhile
// reset stores the date 1752-09-08, empties the output register and sends the
//   sequencer to its fetch step
// errors leave the stored date unchanged
`include "calendar_date_day_stepper_unit_defines.svh"
module calendar_date_day_stepper_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // load_year, load_month, load_day, day_delta, pad
    input  logic [0:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // cur_year, cur_month, cur_day, status
);
    import cdds_pkg::*;

    ctrl_t     ctrl;
    cond_in_t  cnd;
    date_t     cur_date;
    status_t   status;
    logic      in_accept;
    logic      out_free;
    logic      is_add;
    logic      delta_bad;
    logic      loop_done;
    logic      date_in_span;

    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg,  out_data_next;

    // input is taken only in the fetch step
    assign s_axis_tready = ctrl.dp_op == DP_ACCEPT;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign cnd = '{in_valid:  s_axis_tvalid,
                   out_free:  out_free,
                   is_add:    is_add,
                   delta_bad: delta_bad,
                   loop_done: loop_done};

    cdds_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cnd   (cnd),
        .ctrl  (ctrl)
    );

    cdds_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_accept  (in_accept),
        .opcode     (s_axis_tuser[0]),
        .load_year  (s_axis_tdata[11:0]),
        .load_month (s_axis_tdata[15:12]),
        .load_day   (s_axis_tdata[20:16]),
        .day_delta  (s_axis_tdata[30:21]),
        .is_add     (is_add),
        .delta_bad  (delta_bad),
        .loop_done  (loop_done),
        .cur_date   (cur_date),
        .status     (status)
    );

    // output register: loaded in the emit step once the slot is free
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if (ctrl.dp_op == DP_EMIT && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {status, cur_date.day, cur_date.month, cur_date.year};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // span the counter can reach
    assign date_in_span = (cur_date.year >= YEAR_FLOOR) && (cur_date.year <= YEAR_TOP)
        && (cur_date.month >= 4'd1) && (cur_date.month <= 4'd12) && (cur_date.day >= 5'd1);

    // stored date never leaves the span the counter can reach
    `CDDS_ASSERT_ALWAYS(a_date_span, date_in_span)
    // stored date moves only in the commit step
    `CDDS_ASSERT_NEXT(a_date_commit_only, ctrl.dp_op != DP_COMMIT, $stable(cur_date))
    // an accepted word is dispatched in the following cycle
    `CDDS_ASSERT_NEXT(a_accept_dispatch, in_accept, ctrl.dp_op == DP_NONE)

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import cdds_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no word moving on either side
    localparam int RX_HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int RANDOM_WORDS   = 1165;
    localparam int SETTLE_CYCLES  = 30;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    // stored date after a command plus the status it returns
    typedef struct packed {
        date_t   date;
        status_t st;
    } date_result_t;

    class date_tracker;
        date_t        held;
        date_result_t expected_dates[$];
        int           mismatches;

        function new();
            held       = '{year: YEAR_FLOOR, month: RST_MONTH, day: RST_DAY};
            mismatches = 0;
        endfunction

        static function int month_days(int m, int y);
            if (m == 2)
                return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // predicted effect of one accepted command word
        function void note_command(opcode_t op, logic [31:0] word);
            int           y, m, d, n, i;
            int           floor_year, top_year, limit;
            status_t      st;
            date_result_t r;
            floor_year = YEAR_FLOOR;
            top_year   = YEAR_TOP;
            limit      = DELTA_LIMIT;
            st         = ST_OK;
            if (op == OP_LOAD) begin
                y = word[11:0];
                m = word[15:12];
                d = word[20:16];
                if (y <= floor_year || y > top_year)
                    st = ST_BAD_YEAR;
                else if (m < 1 || m > 12)
                    st = ST_BAD_MONTH;
                else if (d < 1 || d > month_days(m, y))
                    st = ST_BAD_DAY;
                else
                    held = '{year: y[11:0], month: m[3:0], day: d[4:0]};
            end
            else begin
                n = $signed(word[30:21]);
                if (n < -limit || n > limit)
                    st = ST_EXCESS;
                else begin
                    y = held.year;
                    m = held.month;
                    d = held.day;
                    // one day per pass, stop at the first range error
                    for (i = 0; i < ((n < 0) ? -n : n) && st == ST_OK; i++) begin
                        if (n < 0) begin
                            if (d <= 1) begin
                                if (m <= 1) begin
                                    y = y - 1;
                                    if (y <= floor_year)
                                        st = ST_BELOW;
                                    m = 12;
                                end
                                else
                                    m = m - 1;
                                d = month_days(m, y);
                            end
                            else
                                d = d - 1;
                        end
                        else begin
                            d = d + 1;
                            if (d > month_days(m, y)) begin
                                m = m + 1;
                                if (m > 12) begin
                                    y = y + 1;
                                    if (y >= top_year)
                                        st = ST_ABOVE;
                                    m = 1;
                                end
                                d = 1;
                            end
                        end
                    end
                    if (st == ST_OK)
                        held = '{year: y[11:0], month: m[3:0], day: d[4:0]};
                end
            end
            r.date = held;
            r.st   = st;
            expected_dates.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_result(logic [23:0] word);
            date_result_t want;
            if (expected_dates.size() == 0) begin
                report_mismatch("result word with nothing pending", word, 0);
                return;
            end
            want = expected_dates.pop_front();
            if (word[11:0] !== want.date.year)
                report_mismatch("cur_year", word[11:0], want.date.year);
            if (word[15:12] !== want.date.month)
                report_mismatch("cur_month", word[15:12], want.date.month);
            if (word[20:16] !== want.date.day)
                report_mismatch("cur_day", word[20:16], want.date.day);
            if (word[23:21] !== want.st)
                report_mismatch("status", word[23:21], want.st);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // load_year, load_month, load_day, day_delta, pad
    logic [0:0]  s_axis_tuser;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // cur_year, cur_month, cur_day, status

    date_tracker tracker;
    int          words_in;
    int          quiet_cycles;

    calendar_date_day_stepper_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // stretch with no idling on either side
    function automatic bit no_idle_window();
        return (words_in >= 300) && (words_in < 500);
    endfunction

    // offer one command word and hold it until taken, then maybe idle
    task send_word(opcode_t op, int y, int m, int d, int delta);
        logic [31:0] w;
        w        = '0;
        w[11:0]  = y[11:0];
        w[15:12] = m[3:0];
        w[20:16] = d[4:0];
        w[30:21] = delta[9:0];
        s_axis_tuser  <= op;
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (!no_idle_window() && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task send_random_word();
        int r, y, m, d;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            // well-formed load, often near the ends of the year range
            case ($urandom_range(0, 5))
                0:       y = $urandom_range(1753, 1760);
                1:       y = $urandom_range(2072, 2080);
                default: y = $urandom_range(1753, 2080);
            endcase
            m = $urandom_range(1, 12);
            d = $urandom_range(1, date_tracker::month_days(m, y));
            send_word(OP_LOAD, y, m, d, $urandom);
        end
        else if (r < 38)
            send_word(OP_LOAD, $urandom, $urandom, $urandom, $urandom);
        else if (r < 92)
            send_word(OP_STEP, $urandom, $urandom, $urandom, $urandom_range(0, 1000) - 500);
        else
            send_word(OP_STEP, $urandom, $urandom, $urandom, $urandom);
    endtask

    // receiver: one long hold-off early on, random stalls otherwise
    initial
    begin
        bit held_off;
        held_off = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held_off && words_in >= 40) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (no_idle_window())
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // word monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.note_command(opcode_t'(s_axis_tuser[0]), s_axis_tdata);
                words_in <= words_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        tracker       = new();
        words_in      = 0;
        quiet_cycles  = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset date steps like any other date
        send_word(OP_STEP, $urandom, $urandom, $urandom, 0);
        send_word(OP_STEP, 12'hfff, 4'hf, 5'h1f, -8);
        send_word(OP_STEP, 0, 0, 0, 400);
        // load faults, first one found decides
        send_word(OP_LOAD, 1752, 1, 1, 0);
        send_word(OP_LOAD, 0, 0, 0, 0);
        send_word(OP_LOAD, 4095, 15, 31, -1);
        send_word(OP_LOAD, 2081, 6, 1, 0);
        send_word(OP_LOAD, 1753, 0, 0, 0);
        send_word(OP_LOAD, 1753, 13, 1, 0);
        send_word(OP_LOAD, 1753, 15, 31, 0);
        send_word(OP_LOAD, 1900, 2, 29, 0);
        send_word(OP_LOAD, 2001, 4, 31, 0);
        send_word(OP_LOAD, 2001, 4, 0, 0);
        // leap day, then delta extremes
        send_word(OP_LOAD, 2000, 2, 29, $urandom);
        send_word(OP_STEP, $urandom, $urandom, $urandom, 500);
        send_word(OP_STEP, $urandom, $urandom, $urandom, -500);
        send_word(OP_STEP, $urandom, $urandom, $urandom, 501);
        send_word(OP_STEP, $urandom, $urandom, $urandom, -501);
        send_word(OP_STEP, $urandom, $urandom, $urandom, -512);
        send_word(OP_STEP, $urandom, $urandom, $urandom, 511);
        // top of range: rollover into the top year is refused
        send_word(OP_LOAD, 2080, 12, 31, 0);
        send_word(OP_STEP, 0, 0, 0, -1);
        send_word(OP_LOAD, 2079, 12, 20, 0);
        send_word(OP_STEP, 0, 0, 0, 20);
        // bottom of range: rollover into the floor year is refused
        send_word(OP_LOAD, 1753, 1, 10, 0);
        send_word(OP_STEP, 0, 0, 0, -20);

        repeat (RANDOM_WORDS) send_random_word();
        s_axis_tvalid <= 1'b0;

        while (tracker.expected_dates.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.expected_dates.size() != 0)
            tracker.report_mismatch("results still pending", tracker.expected_dates.size(), 0);
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cdds_pkg.sv
hdl/cdds_seq.sv
hdl/cdds_dp.sv
hdl/calendar_date_day_stepper_unit.sv
dv/testbench.sv
